// File: rtl/ghsp_pkg.sv
// Shared types, constants and helper functions for the grid heading search block.
package ghsp_pkg;

  localparam int GRID_DIM_DEF   = 128;
  localparam int MAX_STRIDE_DEF = 3;

  // Heading codes, zero based: east, west, south, north.
  localparam logic [1:0] HD_EAST  = 2'd0;
  localparam logic [1:0] HD_WEST  = 2'd1;
  localparam logic [1:0] HD_SOUTH = 2'd2;
  localparam logic [1:0] HD_NORTH = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_ROWS    = 3'd0;
  localparam logic [2:0] REG_COLS    = 3'd1;
  localparam logic [2:0] REG_SROW    = 3'd2;
  localparam logic [2:0] REG_SCOL    = 3'd3;
  localparam logic [2:0] REG_SHEAD   = 3'd4;
  localparam logic [2:0] REG_GROW    = 3'd5;
  localparam logic [2:0] REG_GCOL    = 3'd6;
  localparam logic [2:0] REG_GHEAD   = 3'd7;

  // Heading after a left turn.
  function automatic logic [1:0] turn_left(input logic [1:0] h);
    logic [1:0] r;
    unique case (h)
      HD_EAST:  r = HD_NORTH;
      HD_WEST:  r = HD_SOUTH;
      HD_SOUTH: r = HD_EAST;
      default:  r = HD_WEST;
    endcase
    return r;
  endfunction

  // Heading after a right turn.
  function automatic logic [1:0] turn_right(input logic [1:0] h);
    logic [1:0] r;
    unique case (h)
      HD_EAST:  r = HD_SOUTH;
      HD_WEST:  r = HD_NORTH;
      HD_SOUTH: r = HD_WEST;
      default:  r = HD_EAST;
    endcase
    return r;
  endfunction

  // Search command from the loader to the search engine.
  typedef struct packed {
    logic start;
    logic pose_ok;
  } ghsp_cmd_t;

  // Search status back to the loader.
  typedef struct packed {
    logic        done;
    logic        found;
    logic [15:0] path_len;
  } ghsp_sts_t;

endpackage

// File: rtl/ghsp_search.sv
// Breadth-first search engine: obstacle, visited, distance and queue memories.
module ghsp_search #(
  parameter int GRID_DIM   = ghsp_pkg::GRID_DIM_DEF,
  parameter int MAX_STRIDE = ghsp_pkg::MAX_STRIDE_DEF,
  parameter int RW         = $clog2(GRID_DIM)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  obs_we,
  input  logic [RW-1:0]         obs_row,
  input  logic [RW-1:0]         obs_col,
  input  logic                  obs_wdata,
  input  logic [8:0]            nr,
  input  logic [8:0]            nc,
  input  logic [RW-1:0]         s_row,
  input  logic [RW-1:0]         s_col,
  input  logic [1:0]            s_head,
  input  logic [RW-1:0]         g_row,
  input  logic [RW-1:0]         g_col,
  input  logic [1:0]            g_head,
  input  ghsp_pkg::ghsp_cmd_t   cmd,
  output ghsp_pkg::ghsp_sts_t   sts
);
  import ghsp_pkg::*;

  localparam int CW   = 2 * RW;
  localparam int PW   = CW + 2;
  localparam int NP   = 1 << PW;
  localparam int NC   = 1 << CW;
  localparam int SW   = $clog2(MAX_STRIDE + 1);
  localparam int QW   = PW + 1;

  // Memories: registered reads.
  logic           obs_mem  [NC];
  logic [15:0]    dist_mem [NP];
  logic [PW-1:0]  q_mem    [NP];
  logic           vis_mem  [NP];

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SEED, S_POP, S_POPW, S_DEQ, S_MOVE, S_MOVEW, S_MOVECHK,
    S_TURNL, S_TURNLW, S_TURNR, S_TURNRW, S_DONE
  } st_t;

  st_t            st_r;
  logic [PW:0]    clr_r;
  logic [QW-1:0]  head_r, tail_r;
  logic [PW-1:0]  cur_r;
  logic [15:0]    cd_r;
  logic [RW:0]    rr_r, cc_r;
  logic [SW-1:0]  stp_r;
  logic [PW-1:0]  cand_r;
  logic           found_r, done_r;
  logic [15:0]    res_r;

  // Memory port signals.
  logic           vis_we;
  logic [PW-1:0]  vis_wa;
  logic           vis_wd;
  logic [PW-1:0]  vis_ra;
  logic           vis_rd_r;
  logic           dq_we;
  logic [PW-1:0]  dq_pose;
  logic [15:0]    dq_dist;
  logic [QW-1:0]  q_ra;
  logic [PW-1:0]  q_rd_r;
  logic [PW-1:0]  d_ra;
  logic [15:0]    d_rd_r;
  logic [CW-1:0]  o_ra;
  logic           o_rd_r;

  always_ff @(posedge clk) begin
    if (obs_we) obs_mem[{obs_row, obs_col}] <= obs_wdata;
    o_rd_r <= obs_mem[o_ra];
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_rd_r <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (dq_we) begin
      dist_mem[dq_pose]        <= dq_dist;
      q_mem[tail_r[PW-1:0]]    <= dq_pose;
    end
    q_rd_r <= q_mem[q_ra[PW-1:0]];
    d_rd_r <= dist_mem[d_ra];
  end

  // Current pose fields.
  logic [1:0]    cur_h;
  logic [CW-1:0] cur_cell;
  logic [PW-1:0] goal_p, start_p;
  logic [15:0]   nd;
  assign cur_h    = cur_r[1:0];
  assign cur_cell = cur_r[PW-1:2];
  assign goal_p   = {g_row, g_col, g_head};
  assign start_p  = {s_row, s_col, s_head};
  assign nd       = (cd_r == 16'hFFFF) ? cd_r : cd_r + 16'd1;

  // Next cell along the heading from rr_r/cc_r, with bound check.
  logic [RW:0] nrow, ncol;
  logic        in_grid;
  always_comb begin
    nrow = rr_r;
    ncol = cc_r;
    unique case (cur_h)
      HD_EAST:  ncol = cc_r + 1'b1;
      HD_WEST:  ncol = cc_r - 1'b1;
      HD_SOUTH: nrow = rr_r + 1'b1;
      default:  nrow = rr_r - 1'b1;
    endcase
    in_grid = ({1'b0, nrow} < (RW+2)'(nr)) && ({1'b0, ncol} < (RW+2)'(nc))
              && !nrow[RW] && !ncol[RW];
  end

  logic [PW-1:0] cand_l, cand_r2;
  assign cand_l  = {cur_cell, turn_left(cur_h)};
  assign cand_r2 = {cur_cell, turn_right(cur_h)};

  // Read address and write selection.
  always_comb begin
    vis_we  = 1'b0;
    vis_wa  = cand_r;
    vis_wd  = 1'b1;
    vis_ra  = cand_r;
    dq_we   = 1'b0;
    dq_pose = cand_r;
    dq_dist = nd;
    q_ra    = head_r;
    d_ra    = q_rd_r;
    o_ra    = cand_r[PW-1:2];
    unique case (st_r)
      S_CLEAR: begin
        vis_we = 1'b1;
        vis_wa = clr_r[PW-1:0];
        vis_wd = 1'b0;
      end
      S_SEED: begin
        vis_we  = 1'b1;
        vis_wa  = start_p;
        dq_we   = 1'b1;
        dq_pose = start_p;
        dq_dist = 16'd0;
      end
      S_MOVE: begin
        vis_ra = {nrow[RW-1:0], ncol[RW-1:0], cur_h};
        o_ra   = {nrow[RW-1:0], ncol[RW-1:0]};
      end
      S_TURNL: vis_ra = cand_l;
      S_TURNR: vis_ra = cand_r2;
      S_MOVECHK, S_TURNLW, S_TURNRW: begin
        if (!vis_rd_r && !(st_r == S_MOVECHK && o_rd_r)) begin
          vis_we = 1'b1;
          dq_we  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Search sequencer: one visited check per candidate, memories read-modify-write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      done_r  <= 1'b0;
      found_r <= 1'b0;
      res_r   <= 16'd0;
      clr_r   <= '0;
      head_r  <= '0;
      tail_r  <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (st_r)
        S_IDLE: begin
          if (cmd.start) begin
            if (cmd.pose_ok) begin
              clr_r  <= '0;
              head_r <= '0;
              tail_r <= '0;
              st_r   <= S_CLEAR;
            end else begin
              found_r <= 1'b0;
              res_r   <= 16'd0;
              st_r    <= S_DONE;
            end
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == NP[PW:0] - 1'b1) st_r <= S_SEED;
        end
        S_SEED: begin
          head_r <= '0;
          tail_r <= {{(QW-1){1'b0}}, 1'b1};
          st_r   <= S_POP;
        end
        S_POP: begin
          if (head_r == tail_r) begin
            found_r <= 1'b0;
            res_r   <= 16'd0;
            st_r    <= S_DONE;
          end else begin
            head_r <= head_r + 1'b1;
            st_r   <= S_POPW;
          end
        end
        // Hold the dequeued pose while its distance is read.
        S_POPW: begin
          cur_r <= q_rd_r;
          st_r  <= S_DEQ;
        end
        S_DEQ: begin
          cd_r  <= d_rd_r;
          rr_r  <= {1'b0, cur_r[PW-1:RW+2]};
          cc_r  <= {1'b0, cur_r[RW+1:2]};
          stp_r <= '0;
          if (cur_r == goal_p) begin
            found_r <= 1'b1;
            res_r   <= d_rd_r;
            st_r    <= S_DONE;
          end else begin
            st_r <= S_MOVE;
          end
        end
        S_MOVE: begin
          if (!in_grid || stp_r == SW'(MAX_STRIDE)) begin
            st_r <= S_TURNL;
          end else begin
            cand_r <= {nrow[RW-1:0], ncol[RW-1:0], cur_h};
            rr_r   <= nrow;
            cc_r   <= ncol;
            stp_r  <= stp_r + 1'b1;
            st_r   <= S_MOVEW;
          end
        end
        S_MOVEW: st_r <= S_MOVECHK;
        S_MOVECHK: st_r <= o_rd_r ? S_TURNL : S_MOVE;
        S_TURNL: begin
          cand_r <= cand_l;
          st_r   <= S_TURNLW;
        end
        S_TURNLW: st_r <= S_TURNR;
        S_TURNR: begin
          cand_r <= cand_r2;
          st_r   <= S_TURNRW;
        end
        S_TURNRW: st_r <= S_POP;
        S_DONE: begin
          done_r <= 1'b1;
          st_r   <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
      if (dq_we && st_r != S_SEED) tail_r <= tail_r + 1'b1;
    end
  end

  assign sts.done     = done_r;
  assign sts.found    = found_r;
  assign sts.path_len = res_r;

  // The queue never holds more poses than exist.
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r <= QW'(NP)) else $error("queue overflow");
  // Head never passes tail.
  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("queue underflow");
  // Done lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
endmodule

// File: rtl/grid_heading_shortest_path.sv
// Top level: configuration registers, grid loader, output register and search engine.
//
// Usage: the grid streams in on in_valid/in_ready, one cell per transfer in raster
// order, in_blocked giving the obstacle bit. Cells load at one per cycle while
// in_ready is high. The transfer with in_last_cell set starts the search; the
// loader then drops ready until the search ends and its result has left the output
// register. Search: a clearing pass over every entry of the visited memory
// (4*2^(2*RW) entries, 65536 at the default), then per dequeued pose forward steps
// up to the stride limit and then the left and right turns; the memory reads are
// registered. The result passes through S_DONE and the done strobe to the output
// register once the goal pose is dequeued or the queue runs empty.
// One result transfer follows each last cell on out_valid/out_ready: out_reachable
// and out_command_count (0 when unreachable). A stalled receiver holds the
// result; no new item is taken until it is gone. Cells beyond rows*cols are
// ignored. Configuration writes on cfg_we/cfg_index/cfg_wdata take effect at once
// and must be made only while idle; the block does not enforce this. Synchronous
// reset sets the configuration registers to 1, the load position to 0 and empties the output register.
module grid_heading_shortest_path #(
  parameter int GRID_DIM   = ghsp_pkg::GRID_DIM_DEF,
  parameter int MAX_STRIDE = ghsp_pkg::MAX_STRIDE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_blocked,
  input  logic        in_last_cell,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_command_count,
  output logic        out_reachable,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);
  import ghsp_pkg::*;

  localparam int RW = $clog2(GRID_DIM);

  logic [7:0] rows_r, cols_r, srow_r, scol_r, grow_r, gcol_r;
  logic [2:0] shead_r, ghead_r;

  // Hold configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= 8'd1; cols_r <= 8'd1; srow_r <= 8'd1; scol_r <= 8'd1;
      grow_r <= 8'd1; gcol_r <= 8'd1; shead_r <= 3'd1; ghead_r <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:  rows_r  <= cfg_wdata;
        REG_COLS:  cols_r  <= cfg_wdata;
        REG_SROW:  srow_r  <= cfg_wdata;
        REG_SCOL:  scol_r  <= cfg_wdata;
        REG_SHEAD: shead_r <= cfg_wdata[2:0];
        REG_GROW:  grow_r  <= cfg_wdata;
        REG_GCOL:  gcol_r  <= cfg_wdata;
        REG_GHEAD: ghead_r <= cfg_wdata[2:0];
      endcase
    end
  end

  // Clamp grid size to 1..GRID_DIM.
  logic [8:0] nr, nc;
  always_comb begin
    nr = (rows_r == 8'd0) ? 9'd1 : ({1'b0, rows_r} > 9'(GRID_DIM)) ? 9'(GRID_DIM) : {1'b0, rows_r};
    nc = (cols_r == 8'd0) ? 9'd1 : ({1'b0, cols_r} > 9'(GRID_DIM)) ? 9'(GRID_DIM) : {1'b0, cols_r};
  end

  // Pose validity check.
  logic pose_ok;
  assign pose_ok = (srow_r != 8'd0) && ({1'b0, srow_r} <= nr) && (scol_r != 8'd0)
                && ({1'b0, scol_r} <= nc) && (shead_r != 3'd0) && (shead_r <= 3'd4)
                && (grow_r != 8'd0) && ({1'b0, grow_r} <= nr) && (gcol_r != 8'd0)
                && ({1'b0, gcol_r} <= nc) && (ghead_r != 3'd0) && (ghead_r <= 3'd4);

  logic [RW-1:0] srow0, scol0, grow0, gcol0;
  logic [1:0]    sh0, gh0;
  assign srow0 = RW'(srow_r - 8'd1);
  assign scol0 = RW'(scol_r - 8'd1);
  assign grow0 = RW'(grow_r - 8'd1);
  assign gcol0 = RW'(gcol_r - 8'd1);
  assign sh0   = 2'(shead_r - 3'd1);
  assign gh0   = 2'(ghead_r - 3'd1);

  // Loader: row/column counters instead of a raster divide.
  logic [8:0] lrow_r, lcol_r;
  logic       full_r, busy_r, ov_r;
  logic       in_fire, out_fire, loading;
  ghsp_cmd_t  cmd;
  ghsp_sts_t  sts;
  logic [15:0] cnt_r;
  logic        reach_r;

  assign in_ready = !busy_r && !ov_r;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign loading  = in_fire && !full_r;
  assign cmd.start   = in_fire && in_last_cell;
  assign cmd.pose_ok = pose_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrow_r <= '0;
      lcol_r <= '0;
      full_r <= 1'b0;
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        if (in_last_cell) begin
          lrow_r <= '0;
          lcol_r <= '0;
          full_r <= 1'b0;
          busy_r <= 1'b1;
        end else if (!full_r) begin
          if (lcol_r + 9'd1 >= nc) begin
            lcol_r <= '0;
            lrow_r <= lrow_r + 9'd1;
            if (lrow_r + 9'd1 >= nr) full_r <= 1'b1;
          end else begin
            lcol_r <= lcol_r + 9'd1;
          end
        end
      end
      if (sts.done) begin
        busy_r  <= 1'b0;
        ov_r    <= 1'b1;
      end else if (out_fire) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (sts.done) begin
      cnt_r   <= sts.path_len;
      reach_r <= sts.found;
    end
  end
  assign out_valid         = ov_r;
  assign out_command_count = cnt_r;
  assign out_reachable     = reach_r;

  ghsp_search #(.GRID_DIM(GRID_DIM), .MAX_STRIDE(MAX_STRIDE), .RW(RW)) u_search (
    .clk, .rst_n,
    .obs_we(loading), .obs_row(lrow_r[RW-1:0]), .obs_col(lcol_r[RW-1:0]),
    .obs_wdata(in_blocked), .nr, .nc,
    .s_row(srow0), .s_col(scol0), .s_head(sh0),
    .g_row(grow0), .g_col(gcol0), .g_head(gh0),
    .cmd, .sts
  );

  // No input while a search runs.
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_ready) else $error("input accepted during search");
  // A result only arrives while searching.
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> busy_r) else $error("stray result");
  // Last cell starts a search.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_cell) |=> busy_r) else $error("search not started");
endmodule
